[sv/hcbd_pkg.sv]
// Package for the HTTP chunked body decoder: parser phase and status codes,
// the control and result structs, and the hex digit decode function.
// No dependencies.
`default_nettype none

package hcbd_pkg;

  localparam logic [2:0] PH_SIZE    = 3'd0;
  localparam logic [2:0] PH_SIZE_CR = 3'd1;
  localparam logic [2:0] PH_DATA    = 3'd2;
  localparam logic [2:0] PH_DATA_CR = 3'd3;
  localparam logic [2:0] PH_DATA_LF = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  localparam logic [7:0] ASCII_CR = 8'h0d;
  localparam logic [7:0] ASCII_LF = 8'h0a;

  typedef struct packed {
    logic [2:0] phase;
    logic       digit_seen;
    logic       size_ended;
  } hcbd_ctrl_t;

  typedef struct packed {
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [1:0] status;
  } hcbd_res_t;

  // Bit 4 flags a hex digit, bits 3:0 give its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/hcbd_step.sv]
// Next-state and result logic of the chunked body parser for one byte.
// Depends on hcbd_pkg.
`default_nettype none

module hcbd_step #(
  parameter int SIZE_BITS = 31
) (
  input  hcbd_pkg::hcbd_ctrl_t  ctrl_i,
  input  logic [SIZE_BITS-1:0]  chunk_length_i,
  input  logic [SIZE_BITS-1:0]  bytes_left_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  restart_i,
  output hcbd_pkg::hcbd_ctrl_t  ctrl_o,
  output logic [SIZE_BITS-1:0]  chunk_length_o,
  output logic [SIZE_BITS-1:0]  bytes_left_o,
  output hcbd_pkg::hcbd_res_t   res_o
);
  import hcbd_pkg::*;

  hcbd_ctrl_t           cur;
  logic [SIZE_BITS-1:0] len_cur;
  logic [SIZE_BITS-1:0] left_cur;
  logic [SIZE_BITS-1:0] left_dec;
  logic [SIZE_BITS+3:0] len_wide;
  logic [4:0]           hex;

  always_comb begin
    if (restart_i) begin
      cur      = '{phase: PH_SIZE, digit_seen: 1'b0, size_ended: 1'b0};
      len_cur  = '0;
      left_cur = '0;
    end else begin
      cur      = ctrl_i;
      len_cur  = chunk_length_i;
      left_cur = bytes_left_i;
    end
  end

  assign hex      = hex_decode(data_byte_i);
  // The low nibble of the shifted length is zero, so OR acts as the add.
  assign len_wide = {len_cur, 4'b0000} | {{SIZE_BITS{1'b0}}, hex[3:0]};
  assign left_dec = left_cur - {{(SIZE_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    ctrl_o              = cur;
    chunk_length_o      = len_cur;
    bytes_left_o        = left_cur;
    res_o.payload_valid = 1'b0;
    res_o.payload_byte  = 8'h00;
    case (cur.phase)
      PH_SIZE: begin
        if (data_byte_i == ASCII_CR) begin
          ctrl_o.phase = PH_SIZE_CR;
        end else if (!hex[4] || cur.size_ended) begin
          ctrl_o.size_ended = 1'b1;
        end else begin
          chunk_length_o    = len_wide[SIZE_BITS-1:0];
          ctrl_o.digit_seen = 1'b1;
          if (|len_wide[SIZE_BITS+3:SIZE_BITS]) begin
            ctrl_o.phase = PH_ERROR;
          end
        end
      end
      PH_SIZE_CR: begin
        if (data_byte_i == ASCII_LF) begin
          if (!cur.digit_seen) begin
            ctrl_o.phase = PH_ERROR;
          end else if (len_cur == '0) begin
            ctrl_o.phase = PH_DONE;
          end else begin
            bytes_left_o = len_cur;
            ctrl_o.phase = PH_DATA;
          end
        end else begin
          // A lone CR is an ignored character, which also ends the digits.
          ctrl_o.size_ended = 1'b1;
          ctrl_o.phase      = (data_byte_i == ASCII_CR) ? PH_SIZE_CR : PH_SIZE;
        end
      end
      PH_DATA: begin
        res_o.payload_valid = 1'b1;
        res_o.payload_byte  = data_byte_i;
        bytes_left_o        = left_dec;
        if (left_dec == '0) begin
          ctrl_o.phase = PH_DATA_CR;
        end
      end
      PH_DATA_CR: begin
        ctrl_o.phase = (data_byte_i == ASCII_CR) ? PH_DATA_LF : PH_ERROR;
      end
      PH_DATA_LF: begin
        if (data_byte_i == ASCII_LF) begin
          ctrl_o         = '{phase: PH_SIZE, digit_seen: 1'b0, size_ended: 1'b0};
          chunk_length_o = '0;
        end else begin
          ctrl_o.phase = PH_ERROR;
        end
      end
      PH_DONE: begin
        ctrl_o.phase = PH_DONE;
      end
      default: begin
        ctrl_o.phase = PH_ERROR;
      end
    endcase
    case (ctrl_o.phase)
      PH_DONE:  res_o.status = ST_DONE;
      PH_ERROR: res_o.status = ST_ERROR;
      default:  res_o.status = ST_BUSY;
    endcase
  end

endmodule

`default_nettype wire

[sv/http_chunked_body_decoder_unit.sv]
// HTTP chunked body decoder, top level. One byte in, one result out.
// A result is offered from the result register after its byte has passed through the input register.
// Throughput: one byte per cycle while the output is not stalled; the parser state updates in one step.
// The input register lets a new byte in while a result waits to be taken.
// Reset (rst_ni low) clears the valid flags of both stages and puts the parser at a new body.
// Depends on hcbd_pkg and hcbd_step.
`default_nettype none

module http_chunked_body_decoder_unit #(
  parameter int SIZE_BITS = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       restart_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       payload_valid_o,
  output logic [7:0] payload_byte_o,
  output logic [1:0] status_o
);
  import hcbd_pkg::*;

  logic                 in_valid_q;
  logic [7:0]           byte_q;
  logic                 restart_q;
  logic                 advance;

  hcbd_ctrl_t           ctrl_q, ctrl_d;
  logic [SIZE_BITS-1:0] chunk_length_q, chunk_length_d;
  logic [SIZE_BITS-1:0] bytes_left_q, bytes_left_d;
  hcbd_res_t            res_d, res_q;
  logic                 out_valid_q;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q    <= data_byte_i;
      restart_q <= restart_i;
    end
  end

  hcbd_step #(
    .SIZE_BITS(SIZE_BITS)
  ) u_step (
    .ctrl_i        (ctrl_q),
    .chunk_length_i(chunk_length_q),
    .bytes_left_i  (bytes_left_q),
    .data_byte_i   (byte_q),
    .restart_i     (restart_q),
    .ctrl_o        (ctrl_d),
    .chunk_length_o(chunk_length_d),
    .bytes_left_o  (bytes_left_d),
    .res_o         (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q         <= '{phase: PH_SIZE, digit_seen: 1'b0, size_ended: 1'b0};
      chunk_length_q <= '0;
      bytes_left_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (advance) begin
        ctrl_q         <= ctrl_d;
        chunk_length_q <= chunk_length_d;
        bytes_left_q   <= bytes_left_d;
        out_valid_q    <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_valid_o = res_q.payload_valid;
  assign payload_byte_o  = res_q.payload_byte;
  assign status_o        = res_q.status;

  // While data is due, at least one byte of the chunk is still owed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.phase == PH_DATA |-> bytes_left_q != '0)
    else $error("data phase with no bytes left");

  // Error is sticky until a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !restart_q && ctrl_q.phase == PH_ERROR |=> ctrl_q.phase == PH_ERROR)
    else $error("error phase left without restart");

  // A decoded data byte is only ever reported while the body is in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && payload_valid_o |-> status_o == ST_BUSY)
    else $error("payload byte with final status");

  // Parser state only moves when a byte passes into the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(ctrl_q) && $stable(bytes_left_q))
    else $error("parser state changed without a transfer");

endmodule

`default_nettype wire
